### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Request, result and cell entry layouts plus operation codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  // operation codes carried in the request mode field
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam int FIELD_W = 16;
  localparam int COUNT_W = 7;

  // one held process entry
  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] run_time;
  } entry_t;

  // one request into the queue
  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] in_id;
    logic [FIELD_W-1:0] in_priority;
    logic [FIELD_W-1:0] in_run_time;
  } req_t;

  // one result out of the queue
  typedef struct packed {
    logic               item_valid;
    logic [FIELD_W-1:0] out_id;
    logic [FIELD_W-1:0] out_priority;
    logic [FIELD_W-1:0] out_run_time;
    logic               dropped;
    logic               head_valid;
    logic [FIELD_W-1:0] head_id;
    logic               is_empty;
    logic               is_full;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t fresh;
  } cell_ctl_t;

endpackage

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted-array priority queue of process entries
// Chain of cells kept in ascending priority order, equal priorities in
// arrival order; enqueue inserts in place, dequeue pops the head.
// ----------------------------------------------------------------------------
//  channel   signals             direction  handshake
//  request   start, busy, req    in         accepted when start && !busy
//  result    done, result        out        one cycle pulse on done
//
//  All cells compare and shift in parallel for each request,
//  so busy stays low and a request may be issued every cycle.
//  The result appears on the cycle after the request is accepted.
//  Reset clears the fill count and the result strobe; cell contents stay
//  undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::req_t    req,
  output logic             done,
  output spq_pkg::result_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               accept;
  logic               full;
  logic               do_enq;
  logic               do_deq;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::result_t   result_next;
  logic               ins_vec [CAPACITY];
  spq_pkg::entry_t    entry_vec [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign do_enq = accept && (req.mode == spq_pkg::MODE_ENQ) && !full;
  assign do_deq = accept && (req.mode == spq_pkg::MODE_DEQ) && (count != '0);

  // broadcast the request to the chain
  always_comb begin
    ctl.insert         = do_enq;
    ctl.remove         = do_deq;
    ctl.fresh.id       = req.in_id;
    ctl.fresh.prio     = req.in_priority;
    ctl.fresh.run_time = req.in_run_time;
  end

  // build the chain of cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic            left_ins;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;

    if (k == 0) begin : g_first
      assign left_ins   = 1'b0;
      assign left_entry = '0;
    end else begin : g_inner
      assign left_ins   = ins_vec[k-1];
      assign left_entry = entry_vec[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entry_vec[k+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(k) < count),
      .left_ins    (left_ins),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ins         (ins_vec[k]),
      .entry       (entry_vec[k])
    );
  end

  // form the result from the state as it stands after this request
  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + CNT_W'(1);
    end else if (do_deq) begin
      count_next = count - CNT_W'(1);
    end

    result_next              = '0;
    result_next.dropped      = accept && (req.mode == spq_pkg::MODE_ENQ) && full;
    result_next.item_valid   = do_deq;
    if (do_deq) begin
      result_next.out_id       = entry_vec[0].id;
      result_next.out_priority = entry_vec[0].prio;
      result_next.out_run_time = entry_vec[0].run_time;
    end

    if (do_enq) begin
      result_next.head_id = ins_vec[0] ? req.in_id : entry_vec[0].id;
    end else if (do_deq) begin
      result_next.head_id = (count > CNT_W'(1)) ? entry_vec[1].id : '0;
    end else begin
      result_next.head_id = (count != '0) ? entry_vec[0].id : '0;
    end

    result_next.head_valid  = (count_next != '0);
    result_next.is_empty    = (count_next == '0);
    result_next.is_full     = (count_next == CNT_W'(CAPACITY));
    result_next.entry_count = spq_pkg::COUNT_W'(count_next);
  end

  // hold count and strobe, register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares it with the incoming priority and shifts toward
// the tail on insert or toward the head on remove.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               left_ins,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               ins,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_next;

  // mark slots at or behind the insertion point (monotonic along the chain)
  assign ins = !occupied || (ctl.fresh.prio < entry.prio);

  // pick the next content: take the neighbor, the new entry, or hold
  always_comb begin
    entry_next = entry;
    if (ctl.insert && ins) begin
      entry_next = left_ins ? left_entry : ctl.fresh;
    end else if (ctl.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
